// ===== rtl/sixp_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the six-position accelerometer calibrator
// no dependencies
package sixp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 24;
    localparam int DVD_W     = 31;
    localparam int DVS_W     = 17;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLLECT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 8'd3;

    localparam logic [1:0] PHASE_DETECT  = 2'd0;
    localparam logic [1:0] PHASE_COLLECT = 2'd1;
    localparam logic [1:0] PHASE_SIDE    = 2'd2;
    localparam logic [1:0] PHASE_ALL     = 2'd3;

    localparam logic [2:0] SIDE_NONE = 3'd0;
    localparam logic [5:0] ALL_SIDES = 6'h3F;

    localparam logic signed [15:0] SCALE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SCALE_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } in_t;

    typedef struct packed {
        logic [1:0]         phase;
        logic [2:0]         active_side;
        logic signed [15:0] side_average;
        logic signed [15:0] x_bias;
        logic signed [15:0] y_bias;
        logic signed [15:0] z_bias;
        logic signed [15:0] x_scale;
        logic signed [15:0] y_scale;
        logic signed [15:0] z_scale;
        logic               scale_fault;
    } out_t;

    typedef struct packed {
        logic [14:0] detect_threshold;
        logic [9:0]  stable_samples;
        logic [7:0]  collect_samples;
        logic [14:0] gravity_value;
    } cfg_t;

    // sample plus the sides it faces, bit s-1 for side s
    typedef struct packed {
        in_t        sample;
        logic [5:0] facing;
    } qitem_t;

endpackage

// ===== rtl/six_position_accel_calibrator.sv =====
`timescale 1ns / 1ps
// top level of the six-position accelerometer calibrator: config registers,
// front classifier queue and back processor; depends on sixp_pkg and submodules
//
// usage: samples enter on s_valid/s_ready (s_data: accel_x/y/z, Q8.8) and each
// request yields exactly one result on m_valid/m_ready. configuration is written
// on cfg_valid/cfg_ready (always ready) by register index while the block is idle;
// indexes above 3 are ignored.
// processing: a detecting or collecting sample goes from the idle state to the
// output state and into the result register; a sample that finishes a side runs
// the shared divider for the average, and the sample that finishes the sixth side
// also runs up to three scale divisions. one sample is in processing at a time,
// with a two-entry input queue in front.
// reset: all sides, m_valid, biases and scales cleared; configuration to defaults.
// receiver stall: the result register holds its value; processing of the next
// sample finishes and waits, and the input queue fills then drops s_ready.
module six_position_accel_calibrator import sixp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);
    cfg_t   cfg_reg;
    logic   q_valid, q_ready;
    qitem_t q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{detect_threshold: 15'd2048, stable_samples: 10'd200,
                         collect_samples: 8'd30, gravity_value: 15'd2510};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD: cfg_reg.detect_threshold <= cfg_data[14:0];
                CFG_STABLE:    cfg_reg.stable_samples   <= cfg_data[9:0];
                CFG_COLLECT:   cfg_reg.collect_samples  <= cfg_data[7:0];
                CFG_GRAVITY:   cfg_reg.gravity_value    <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    sixp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .threshold (cfg_reg.detect_threshold),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data)
    );

    sixp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule

// ===== rtl/sixp_front.sv =====
`timescale 1ns / 1ps
// front: classifies each sample against the threshold and queues it
// depends on sixp_pkg
module sixp_front import sixp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    input  logic [14:0] threshold,
    output logic        q_valid,
    input  logic        q_ready,
    output qitem_t      q_data
);
    qitem_t     mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic [5:0] facing;
    logic signed [16:0] t_pos, t_neg, vx, vy, vz;
    logic       push, pop;

    assign t_pos = {2'b00, threshold};
    assign t_neg = -t_pos;
    assign vx = {s_data.accel_x[15], s_data.accel_x};
    assign vy = {s_data.accel_y[15], s_data.accel_y};
    assign vz = {s_data.accel_z[15], s_data.accel_z};

    always_comb begin
        facing[0] = vx > t_pos;
        facing[1] = vx < t_neg;
        facing[2] = vy > t_pos;
        facing[3] = vy < t_neg;
        facing[4] = vz > t_pos;
        facing[5] = vz < t_neg;
    end

    assign s_ready = count_reg != 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_data  = mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= '{sample: s_data, facing: facing};
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/sixp_div.sv =====
`timescale 1ns / 1ps
// restoring unsigned divider, one quotient bit per cycle
// depends on sixp_pkg
module sixp_div import sixp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg, done_reg;
    logic [DVS_W:0]   trial;

    assign trial = {rem_reg, q_reg[DVD_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                q_reg    <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= 5'(DVD_W - 1);
            end else if (busy_reg) begin
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_reg <= DVS_W'(trial - {1'b0, dvs_reg});
                    q_reg   <= {q_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= DVS_W'(trial);
                    q_reg   <= {q_reg[DVD_W-2:0], 1'b0};
                end
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// ===== rtl/sixp_back.sv =====
`timescale 1ns / 1ps
// back: detection, collection, averaging and final offset/scale computation
// depends on sixp_pkg and sixp_div
module sixp_back import sixp_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   q_valid,
    output logic   q_ready,
    input  qitem_t q_data,
    output logic   m_valid,
    input  logic   m_ready,
    output out_t   m_data
);
    typedef enum logic [1:0] {MODE_DETECT, MODE_COLLECT, MODE_DONE} mode_t;
    typedef enum logic [2:0] {ST_IDLE, ST_AVG, ST_RD, ST_AXIS, ST_SCL, ST_OUT} state_t;

    state_t state_reg;
    mode_t  mode_reg;
    logic [2:0]  cur_reg;
    logic [9:0]  stab_reg;
    logic [7:0]  cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [5:0]  done_reg;
    logic        fault_reg;
    logic [1:0]  axis_reg;
    logic        neg_reg;
    logic signed [15:0] side_mem [6];
    logic signed [15:0] up_reg, dn_reg;
    logic signed [15:0] off_reg [3];
    logic signed [15:0] scl_reg [3];
    logic [1:0]  phase_reg;
    logic [2:0]  side_reg;
    logic signed [15:0] avg_reg;
    logic        m_valid_reg;
    out_t        m_data_reg;

    // detect step
    logic [2:0] det_cur;
    logic [9:0] det_stab;
    logic       det_go;
    logic [2:0] cur_idx;
    always_comb begin
        det_cur  = cur_reg;
        det_stab = stab_reg;
        det_go   = 1'b0;
        cur_idx  = cur_reg - 3'd1;
        if (cur_reg == SIDE_NONE) begin
            for (int s = 5; s >= 0; s--) begin
                if (!done_reg[s] && q_data.facing[s]) det_cur = 3'(s + 1);
            end
            det_stab = '0;
            if (det_cur != SIDE_NONE) begin
                if (cfg.stable_samples == 10'd0) det_go = 1'b1;
                else det_stab = 10'd1;
            end
        end else if (q_data.facing[cur_idx]) begin
            if (stab_reg >= cfg.stable_samples) det_go = 1'b1;
            else det_stab = stab_reg + 10'd1;
        end else begin
            det_cur  = SIDE_NONE;
            det_stab = '0;
        end
    end

    // collect step
    logic signed [15:0] axis_val;
    logic signed [SUM_W-1:0] col_sum;
    logic [7:0] col_cnt, n_eff;
    logic       col_fin;
    always_comb begin
        case (cur_idx[2:1])
            2'd0:    axis_val = q_data.sample.accel_x;
            2'd1:    axis_val = q_data.sample.accel_y;
            default: axis_val = q_data.sample.accel_z;
        endcase
        n_eff   = (cfg.collect_samples == 8'd0) ? 8'd1 : cfg.collect_samples;
        col_sum = sum_reg + SUM_W'(axis_val);
        col_cnt = cnt_reg + 8'd1;
        col_fin = col_cnt >= n_eff;
    end

    // shared divider
    logic             div_start, div_busy, div_done;
    logic [DVD_W-1:0] div_dvd, div_q;
    logic [DVS_W-1:0] div_dvs;
    logic signed [SUM_W-1:0] abs_sum;
    logic signed [16:0] diff, pair;
    logic [DVS_W-1:0]   abs_diff;

    assign abs_sum  = col_sum[SUM_W-1] ? -col_sum : col_sum;
    assign diff     = {up_reg[15], up_reg} - {dn_reg[15], dn_reg};
    assign pair     = {up_reg[15], up_reg} + {dn_reg[15], dn_reg};
    assign abs_diff = diff[16] ? DVS_W'(-diff) : DVS_W'(diff);

    always_comb begin
        div_start = 1'b0;
        div_dvd   = DVD_W'(unsigned'(abs_sum));
        div_dvs   = DVS_W'(n_eff);
        if (state_reg == ST_IDLE && q_valid && mode_reg == MODE_COLLECT && col_fin) begin
            div_start = 1'b1;
        end else if (state_reg == ST_AXIS && diff != 17'sd0) begin
            div_start = 1'b1;
            div_dvd   = DVD_W'({cfg.gravity_value, 15'd0});
            div_dvs   = abs_diff;
        end
    end

    sixp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_ready = state_reg == ST_IDLE;

    logic signed [15:0] avg_q;
    logic [5:0]         done_new;
    logic signed [15:0] scale_q;
    logic               scale_sat;
    always_comb begin
        avg_q    = neg_reg ? -16'(div_q) : 16'(div_q);
        done_new = done_reg | (6'd1 << cur_idx);
        scale_sat = 1'b0;
        if (!neg_reg) begin
            if (div_q > DVD_W'(32767)) begin
                scale_q = SCALE_MAX; scale_sat = 1'b1;
            end else begin
                scale_q = 16'(div_q);
            end
        end else begin
            if (div_q > DVD_W'(32768)) begin
                scale_q = SCALE_MIN; scale_sat = 1'b1;
            end else begin
                scale_q = -16'(div_q);
            end
        end
    end

    // result register loads when empty or being drained
    logic out_load;
    assign out_load = state_reg == ST_OUT && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_AVG && div_done) begin
            side_mem[cur_idx] <= avg_q;
        end
        if (state_reg == ST_RD) begin
            up_reg <= side_mem[{axis_reg, 1'b0}];
            dn_reg <= side_mem[{axis_reg, 1'b1}];
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_DETECT;
            cur_reg     <= SIDE_NONE;
            stab_reg    <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            done_reg    <= '0;
            fault_reg   <= 1'b0;
            axis_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                off_reg[i] <= '0;
                scl_reg[i] <= '0;
            end
        end else begin
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        avg_reg   <= '0;
                        state_reg <= ST_OUT;
                        case (mode_reg)
                            MODE_DETECT: begin
                                cur_reg   <= det_cur;
                                stab_reg  <= det_stab;
                                phase_reg <= PHASE_DETECT;
                                side_reg  <= det_cur;
                                if (det_go) begin
                                    mode_reg <= MODE_COLLECT;
                                    cnt_reg  <= '0;
                                    sum_reg  <= '0;
                                end
                            end
                            MODE_COLLECT: begin
                                side_reg <= cur_reg;
                                if (col_fin) begin
                                    neg_reg   <= col_sum[SUM_W-1];
                                    state_reg <= ST_AVG;
                                end else begin
                                    sum_reg   <= col_sum;
                                    cnt_reg   <= col_cnt;
                                    phase_reg <= PHASE_COLLECT;
                                end
                            end
                            default: begin
                                phase_reg <= PHASE_ALL;
                                side_reg  <= SIDE_NONE;
                            end
                        endcase
                    end
                end
                ST_AVG: begin
                    if (div_done) begin
                        avg_reg   <= avg_q;
                        phase_reg <= PHASE_SIDE;
                        done_reg  <= done_new;
                        cur_reg   <= SIDE_NONE;
                        stab_reg  <= '0;
                        cnt_reg   <= '0;
                        sum_reg   <= '0;
                        if (done_new == ALL_SIDES) begin
                            mode_reg  <= MODE_DONE;
                            axis_reg  <= '0;
                            fault_reg <= 1'b0;
                            state_reg <= ST_RD;
                        end else begin
                            mode_reg  <= MODE_DETECT;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_RD: state_reg <= ST_AXIS;
                ST_AXIS: begin
                    off_reg[axis_reg] <= pair[16:1];
                    neg_reg <= diff[16];
                    if (diff == 17'sd0) begin
                        scl_reg[axis_reg] <= SCALE_MAX;
                        fault_reg <= 1'b1;
                        if (axis_reg == 2'd2) begin
                            mode_reg  <= MODE_DONE;
                            state_reg <= ST_OUT;
                        end else begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_RD;
                        end
                    end else begin
                        state_reg <= ST_SCL;
                    end
                end
                ST_SCL: begin
                    if (div_done) begin
                        scl_reg[axis_reg] <= scale_q;
                        if (scale_sat) fault_reg <= 1'b1;
                        if (axis_reg == 2'd2) begin
                            mode_reg  <= MODE_DONE;
                            state_reg <= ST_OUT;
                        end else begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_data_reg  <= '{phase: phase_reg, active_side: side_reg,
                                         side_average: avg_reg,
                                         x_bias: off_reg[0], y_bias: off_reg[1],
                                         z_bias: off_reg[2], x_scale: scl_reg[0],
                                         y_scale: scl_reg[1], z_scale: scl_reg[2],
                                         scale_fault: fault_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    a_axis_all: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_AXIS |-> done_reg == ALL_SIDES) else $error("axis pass early");
    a_avg_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_AVG |-> mode_reg == MODE_COLLECT) else $error("average outside collect");
    a_collect_side: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_COLLECT |-> cur_reg != SIDE_NONE) else $error("collect without side");
endmodule

// ===== tb/sv/six_position_accel_calibrator_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the six-position accelerometer calibrator
// depends on sixp_pkg and six_position_accel_calibrator
module six_position_accel_calibrator_tb;
    import sixp_pkg::*;

    typedef enum int {CAL_DETECT, CAL_COLLECT, CAL_DONE} cal_mode_e;

    class calib_scoreboard;
        int        thr, stable_n, collect_n, gravity;
        cal_mode_e mode;
        int        cur_side, stable_cnt, sample_cnt, axis_sum;
        bit [5:0]  done;
        int        side_val[6];
        int        cal_res[6];
        bit        fault;
        out_t      pending[$];
        int        errors;

        function new();
            thr = 2048; stable_n = 200; collect_n = 30; gravity = 2510;
            mode = CAL_DETECT; cur_side = 0; stable_cnt = 0; sample_cnt = 0;
            axis_sum = 0; done = '0; fault = 0; errors = 0;
            foreach (cal_res[i]) cal_res[i] = 0;
            foreach (side_val[i]) side_val[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
            case (idx)
                CFG_THRESHOLD: thr = int'(d[14:0]);
                CFG_STABLE:    stable_n = int'(d[9:0]);
                CFG_COLLECT:   collect_n = int'(d[7:0]);
                CFG_GRAVITY:   gravity = int'(d[14:0]);
                default: ;
            endcase
        endfunction

        function bit beyond(int s, int v);
            if (s % 2) return v > thr;
            return v < -thr;
        endfunction

        function void advance();
            if (stable_cnt >= stable_n) begin
                mode = CAL_COLLECT;
                sample_cnt = 0;
                axis_sum = 0;
            end else begin
                stable_cnt++;
            end
        endfunction

        function void finish_scales();
            int     up, dn, sum;
            longint d, q;
            fault = 0;
            for (int a = 0; a < 3; a++) begin
                up = side_val[2*a];
                dn = side_val[2*a+1];
                sum = up + dn;
                cal_res[a] = sum >>> 1;
                d = up - dn;
                if (d == 0) begin
                    q = 32767;
                    fault = 1;
                end else begin
                    q = (longint'(gravity) * 2 * 16384) / d;
                    if (q > 32767) begin q = 32767; fault = 1; end
                    if (q < -32768) begin q = -32768; fault = 1; end
                end
                cal_res[3+a] = int'(q);
            end
        endfunction

        function void note_sample(in_t smp);
            int   ax[3];
            int   n, s, avg;
            out_t o;
            ax[0] = smp.accel_x; ax[1] = smp.accel_y; ax[2] = smp.accel_z;
            o = '0;
            if (mode == CAL_DETECT) begin
                if (cur_side == 0) begin
                    for (int k = 1; k <= 6; k++) begin
                        if (!done[k-1] && beyond(k, ax[(k-1)/2])) begin
                            cur_side = k;
                            stable_cnt = 0;
                            break;
                        end
                    end
                    if (cur_side != 0) advance();
                end else if (beyond(cur_side, ax[(cur_side-1)/2])) begin
                    advance();
                end else begin
                    // lost side, this sample does not select a new one
                    cur_side = 0;
                    stable_cnt = 0;
                end
                o.phase = PHASE_DETECT;
                o.active_side = 3'(cur_side);
            end else if (mode == CAL_COLLECT) begin
                n = (collect_n == 0) ? 1 : collect_n;
                s = cur_side;
                axis_sum += ax[(s-1)/2];
                sample_cnt++;
                o.active_side = 3'(s);
                if (sample_cnt >= n) begin
                    avg = axis_sum / n;
                    side_val[s-1] = avg;
                    done[s-1] = 1'b1;
                    o.phase = PHASE_SIDE;
                    o.side_average = 16'(avg);
                    cur_side = 0; stable_cnt = 0; sample_cnt = 0; axis_sum = 0;
                    if (done == ALL_SIDES) begin
                        finish_scales();
                        mode = CAL_DONE;
                    end else begin
                        mode = CAL_DETECT;
                    end
                end else begin
                    o.phase = PHASE_COLLECT;
                end
            end else begin
                o.phase = PHASE_ALL;
                o.active_side = SIDE_NONE;
            end
            o.x_bias = 16'(cal_res[0]); o.y_bias = 16'(cal_res[1]);
            o.z_bias = 16'(cal_res[2]);
            o.x_scale = 16'(cal_res[3]); o.y_scale = 16'(cal_res[4]);
            o.z_scale = 16'(cal_res[5]);
            o.scale_fault = fault;
            pending.push_back(o);
        endfunction

        function void cmp(string f, logic signed [16:0] e, logic signed [16:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t mismatch %s expected %0d got %0d", $time, f, e, a);
            end
        endfunction

        function void check_result(out_t got);
            out_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result expected none got %h", $time, got);
                return;
            end
            e = pending.pop_front();
            cmp("phase", e.phase, got.phase);
            cmp("active_side", e.active_side, got.active_side);
            cmp("side_average", e.side_average, got.side_average);
            cmp("x_bias", e.x_bias, got.x_bias);
            cmp("y_bias", e.y_bias, got.y_bias);
            cmp("z_bias", e.z_bias, got.z_bias);
            cmp("x_scale", e.x_scale, got.x_scale);
            cmp("y_scale", e.y_scale, got.y_scale);
            cmp("z_scale", e.z_scale, got.z_scale);
            cmp("scale_fault", e.scale_fault, got.scale_fault);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    calib_scoreboard sb;
    int              burst_left = 0;
    logic [9:0]      stall_cyc = '0;
    int              side_avg[6];
    bit              axis_jitter[3];

    six_position_accel_calibrator u_top (.*);

    always #2 aclk = ~aclk;

    // receiver stall pattern cycles through four modes
    always @(posedge aclk) begin
        stall_cyc <= stall_cyc + 10'd1;
        case (stall_cyc[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= (stall_cyc[2:0] != 3'd5);
            default: m_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    task automatic send_sample(in_t v);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_data <= v;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(v);
    endtask

    task automatic send_xyz(int x, int y, int z);
        in_t v;
        v.accel_x = 16'(x); v.accel_y = 16'(y); v.accel_z = 16'(z);
        send_sample(v);
    endtask

    task automatic send_axis(int s, int val);
        case ((s - 1) / 2)
            0: send_xyz(val, 0, 0);
            1: send_xyz(0, val, 0);
            default: send_xyz(0, 0, val);
        endcase
    endtask

    // hold off until every outstanding result has been returned
    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int d);
        cfg_index <= idx;
        cfg_data <= CFG_DAT_W'(d);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, CFG_DAT_W'(d));
        @(posedge aclk);
    endtask

    task automatic write_all(int t, int st, int col, int g);
        wait_drained();
        write_reg(CFG_THRESHOLD, t);
        write_reg(CFG_STABLE, st);
        write_reg(CFG_COLLECT, col);
        write_reg(CFG_GRAVITY, g);
    endtask

    function automatic int qualifying(int s);
        if (s % 2) return $urandom_range(32767, sb.thr + 1);
        return -int'($urandom_range(32768, sb.thr + 1));
    endfunction

    // drive well-formed samples until the target side is stored
    task automatic finish_side(int target);
        int s;
        while (!sb.done[target-1]) begin
            if (sb.mode == CAL_COLLECT) begin
                s = sb.cur_side;
                send_axis(s, side_avg[s-1] +
                          (axis_jitter[(s-1)/2] ? $urandom_range(0, 6) - 3 : 0));
            end else begin
                send_axis(target, qualifying(target));
            end
        end
    endtask

    // random samples and broken approach sequences
    task automatic noise_items(int count);
        int s, m;
        repeat (count) begin
            if ($urandom_range(0, 9) < 4) begin
                send_xyz($urandom, $urandom, $urandom);
            end else begin
                s = $urandom_range(1, 6);
                m = $urandom_range(1, (sb.stable_n < 10) ? sb.stable_n : 10);
                repeat (m) send_axis(s, qualifying(s));
                send_xyz(0, 0, 0);
            end
        end
    endtask

    initial begin
        int up, dn;
        sb = new();
        // per-axis targets: equal pair, tiny span either way, or normal span
        for (int a = 0; a < 3; a++) begin
            up = $urandom_range(0, 6000) - 3000;
            axis_jitter[a] = 0;
            case ($urandom_range(0, 3))
                0: dn = up;
                1: dn = up - $urandom_range(1, 3);
                2: dn = up + $urandom_range(1, 3);
                default: begin
                    up = $urandom_range(1000, 9000);
                    dn = -int'($urandom_range(1000, 9000));
                    axis_jitter[a] = 1;
                end
            endcase
            side_avg[2*a] = up;
            side_avg[2*a+1] = dn;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default settings: extremes, select, lose and reselect
        send_xyz(0, 0, 0);
        send_xyz(32767, 32767, 32767);
        send_xyz(32767, 0, 0);
        send_xyz(-32768, -32768, -32768);
        send_xyz(-32768, 0, 0);
        send_xyz(-32768, 0, 0);
        send_xyz(0, 32767, 0);
        send_xyz(0, -32768, 0);
        send_xyz(0, 0, 32767);
        send_xyz(0, 0, -32768);
        send_xyz(16'sh5555, -16'sh5556, 16'sh2AAA);
        send_xyz(2049, -2049, 2048);

        // maximum settings: only the most negative value can qualify
        write_all(32767, 1023, 255, 32767);
        write_reg(8'd5, 16'hFFFF);
        repeat (40) send_xyz($urandom, $urandom, $urandom);
        repeat (6) send_xyz(-32768, $urandom, $urandom);

        // zero settings: selecting sample accepts, collect count acts as one
        write_all(0, 0, 0, 1);
        send_xyz(0, 0, 0);
        finish_side(1);

        for (int s = 2; s <= 6; s++) begin
            write_all($urandom_range(0, 30000), $urandom_range(1, 6),
                      (s == 4) ? 255 : $urandom_range(1, 12),
                      (s == 6) ? 32767 : $urandom_range(1, 32767));
            noise_items(s == 4 ? 10 : 25);
            finish_side(s);
        end
        noise_items(20);

        wait_drained();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("six_position_accel_calibrator regression: pass");
        end else begin
            $display("six_position_accel_calibrator regression: fail");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("six_position_accel_calibrator regression: fail");
        $finish;
    end

endmodule
